/* hdl/ptts_pkg.sv */
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and constants of the periodic task tick scheduler
// Sizes of the slot table, field widths, command kinds and sequencer states.
// ----------------------------------------------------------------------------
package ptts_pkg;

  // Slot table depth and index width
  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths of one input item and one result item
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 8;
  localparam int TASK_W  = 3;

  // Stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  // Command kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_CREATE  = 3'd1,
    KIND_DELETE  = 3'd2,
    KIND_SUSPEND = 3'd3,
    KIND_RESUME  = 3'd4
  } kind_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN,
    ST_CMD
  } state_e;

endpackage

/* hdl/periodic_task_tick_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler: time-triggered cooperative task scheduler
// Slot table of periodic tasks, walked one slot per cycle on each tick unless a full output register holds the walk.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries commands: tuser holds the kind (tick, create,
//   delete, suspend, resume), tdata holds slot, period and first delay.
//   The master stream returns results: tdata holds the task index, tuser
//   holds the fired and error flags, tlast marks the final result of a
//   command.
//   A create, delete, suspend or resume gives a single result. A tick
//   walks the slots one per cycle, unless a full output register holds it,
//   through the shared countdown decrementer, then closes the walk. It
//   gives one result per due slot in ascending order, or one result with
//   fired low when nothing is due.
//   One due slot is held back until the next is found, so tlast can be
//   set on the final one.
//   s_axis_tready_o is high only between commands. A stalled receiver
//   stops the walk at the next due slot that finds the output register
//   still full; nothing is dropped.
//   Reset empties every slot and clears the output valid flag.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [2:0] slot, [10:3] period, [18:11] first_delay, [23:19] zero
  input  logic [ptts_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [2:0] kind
  input  logic [ptts_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [2:0] task_index, [7:3] zero
  output logic [ptts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] fired, [1] error
  output logic [ptts_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);
  import ptts_pkg::*;

  // Sequencer and command registers
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [KIND_W-1:0]  kind_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [CNT_W-1:0]   period_q;
  logic [CNT_W-1:0]   delay_q;
  logic               pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;

  // Slot table
  logic [NUM_SLOTS-1:0] valid_q;
  logic [NUM_SLOTS-1:0] susp_q;
  logic [CNT_W-1:0]     cnt_q [NUM_SLOTS];
  logic [CNT_W-1:0]     per_q [NUM_SLOTS];

  // Output register
  logic               out_valid_q;
  logic               out_fired_q, out_err_q, out_last_q;
  logic [TASK_W-1:0]  out_idx_q;

  // Table access
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_valid, rd_susp, rd_active, rd_zero;
  logic [CNT_W-1:0]   rd_cnt, rd_per;
  logic [CNT_W-1:0]   dec_src, dec_res;
  logic               in_range;

  // Table write strobes
  logic               cnt_we, per_we, valid_we, susp_we;
  logic [CNT_W-1:0]   cnt_wdata, per_wdata;
  logic               valid_wdata, susp_wdata;

  // Output load strobes
  logic               out_free;
  logic               out_load;
  logic               out_fired_d, out_err_d, out_last_d;
  logic [TASK_W-1:0]  out_idx_d;
  logic               accept;

  // Read the slot under the walk or the command slot
  assign rd_addr   = (state_q == ST_CMD) ? IDX_W'(slot_q) : idx_q;
  assign rd_valid  = valid_q[rd_addr];
  assign rd_susp   = susp_q[rd_addr];
  assign rd_cnt    = cnt_q[rd_addr];
  assign rd_per    = per_q[rd_addr];
  assign rd_active = rd_valid && !rd_susp;
  assign rd_zero   = (rd_cnt == '0);
  assign in_range  = (int'(slot_q) < NUM_SLOTS);

  // Shared decrementer: count down, or reload with period minus one
  assign dec_src = rd_zero ? rd_per : rd_cnt;
  assign dec_res = dec_src - CNT_W'(1);

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Next state, table strobes and result loads
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    cnt_we       = 1'b0;
    per_we       = 1'b0;
    valid_we     = 1'b0;
    susp_we      = 1'b0;
    cnt_wdata    = dec_res;
    per_wdata    = '0;
    valid_wdata  = 1'b0;
    susp_wdata   = 1'b0;
    out_load     = 1'b0;
    out_fired_d  = 1'b0;
    out_idx_d    = '0;
    out_err_d    = 1'b0;
    out_last_d   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = (s_axis_tuser_i == KIND_TICK) ? ST_WALK : ST_CMD;
        end
      end
      ST_WALK: begin
        // Hold on a second due slot while the output register is full
        if (!(rd_active && rd_zero && pend_valid_q && !out_free)) begin
          cnt_we = rd_active;
          if (rd_active && rd_zero) begin
            if (pend_valid_q) begin
              out_load    = 1'b1;
              out_fired_d = 1'b1;
              out_idx_d   = TASK_W'(pend_idx_q);
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_idx_d   = idx_q;
          end
          if (idx_q == IDX_W'(NUM_SLOTS - 1)) begin
            state_d = ST_FIN;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      ST_FIN: begin
        // Emit the held due slot as final, or a single empty result
        if (out_free) begin
          out_load    = 1'b1;
          out_fired_d = pend_valid_q;
          out_idx_d   = pend_valid_q ? TASK_W'(pend_idx_q) : '0;
          state_d     = ST_IDLE;
        end
      end
      ST_CMD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          unique case (kind_q)
            KIND_CREATE: begin
              if (!in_range || rd_valid) begin
                out_err_d = 1'b1;
              end else begin
                valid_we    = 1'b1;
                valid_wdata = 1'b1;
                susp_we     = 1'b1;
                cnt_we      = 1'b1;
                cnt_wdata   = delay_q;
                per_we      = 1'b1;
                per_wdata   = period_q;
              end
            end
            KIND_DELETE: begin
              if (in_range && rd_valid) begin
                valid_we  = 1'b1;
                susp_we   = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = '0;
                per_we    = 1'b1;
              end
            end
            KIND_SUSPEND: begin
              susp_we    = in_range && rd_valid;
              susp_wdata = 1'b1;
            end
            KIND_RESUME: begin
              susp_we = in_range && rd_valid;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_idx_q   <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      pend_idx_q   <= pend_idx_d;
    end
  end

  // Capture the accepted command
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= s_axis_tuser_i;
      slot_q   <= s_axis_tdata_i[2:0];
      period_q <= s_axis_tdata_i[10:3];
      delay_q  <= s_axis_tdata_i[18:11];
    end
  end

  // Update the slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      susp_q  <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cnt_q[i] <= '0;
        per_q[i] <= '0;
      end
    end else begin
      if (valid_we) valid_q[rd_addr] <= valid_wdata;
      if (susp_we)  susp_q[rd_addr]  <= susp_wdata;
      if (cnt_we)   cnt_q[rd_addr]   <= cnt_wdata;
      if (per_we)   per_q[rd_addr]   <= per_wdata;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fired_q <= out_fired_d;
      out_idx_q   <= out_idx_d;
      out_err_q   <= out_err_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - TASK_W)'(0), out_idx_q};
  assign m_axis_tuser_o  = {out_err_q, out_fired_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* hdl/ptts_checker.sv */
// ----------------------------------------------------------------------------
// ptts_checker: port-level checks of the periodic task tick scheduler
// Watches the command and result streams and flags illegal behavior.
// ----------------------------------------------------------------------------
module ptts_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [ptts_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [ptts_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [ptts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [ptts_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,
  input logic                             m_axis_tlast_o
);
  import ptts_pkg::*;

  // Hold a stalled result item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled result item changed");

  // Drop ready while a command is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready high right after an accepted item");

  // Only a fired result may be followed by more results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o &&
      (m_axis_tdata_o == '0))
    else $error("non-fired result not final or has an index");

  // Error never comes with a fired task
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tuser_o[0])
    else $error("error and fired both set");

  // Accept no command while a non-final result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("ready while a tick is still reporting");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);
